>>> hdl/conv3x3_border_modes_assert.svh
// assertion macros for the 3x3 convolution block
`ifndef CONV3X3_BORDER_MODES_ASSERT_SVH
`define CONV3X3_BORDER_MODES_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is asserted
`define CBM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("conv3x3_border_modes: assertion failed");

// clocked check that also runs through reset
`define CBM_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("conv3x3_border_modes: reset assertion failed");

`else

`define CBM_ASSERT(lbl, clk, rstn, prop)
`define CBM_ASSERT_RST(lbl, clk, prop)

`endif

`endif

>>> hdl/c3bm_pkg.sv
package c3bm_pkg;

    // parameter defaults
    localparam int MAX_DIM_DEF    = 16;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int COEF_BITS_DEF  = 8;

    // fixed field widths
    localparam int DIM_REG_W = 5;
    localparam int MODE_W    = 2;
    localparam int COORD_W   = 4;
    localparam int VALUE_W   = 20;
    localparam int CFG_IDX_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int N_SLOTS   = 4;
    localparam int MIN_DIM   = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_ROWS    = 3'd0,
        REG_IMAGE_COLS    = 3'd1,
        REG_BORDER_MODE   = 3'd2,
        REG_KERNEL_TOP    = 3'd3,
        REG_KERNEL_MIDDLE = 3'd4,
        REG_KERNEL_BOTTOM = 3'd5
    } cfg_reg_t;

    // border mode codes; codes at or above MODE_NONE drop ring results
    localparam logic [MODE_W-1:0] MODE_COPY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ZERO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd2;

    // one result word
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VALUE_W-1:0] value;
        logic               border;
    } result_t;

    // tdata packing, out_row in the lowest bits
    function automatic logic [M_TDATA_W-1:0] pack_result(input result_t r);
        logic [M_TDATA_W-1:0] w;
        w = '0;
        w[COORD_W-1:0]                         = r.row;
        w[2*COORD_W-1:COORD_W]                 = r.col;
        w[2*COORD_W+VALUE_W-1:2*COORD_W]       = r.value;
        w[2*COORD_W+VALUE_W]                   = r.border;
        return w;
    endfunction

endpackage

>>> hdl/conv3x3_border_modes.sv
// 3x3 image convolution with selectable border handling.
// s_ channel: one pixel per word in raster order, s_tdata[PIXEL_BITS-1:0].
// m_ channel: result words, m_tdata = {is_border, value, out_col, out_row}
// from the highest bit down, m_tlast marks the last result caused by a pixel.
// cfg_ channel: register writes (rows, cols, mode, three kernel rows),
// always ready; write only while the block is idle.
// A pixel's results pass stage 1, stage 2, the burst slots and m_tdata_reg.
// Throughput: one pixel per cycle while m_tready is high and each pixel
// causes at most one result; in the last column and last row a pixel can
// cause two or four results, and the burst slots then hold back the input.
// The line stores sit in one dual-port memory ({newer, older} per column),
// read on accept and written back when stage 1 moves on.
// Reset clears position counters, pipeline valids and the per-column valid
// bits of the line stores, so unwritten columns read as zero.
// When m_tready is low the pipeline fills, then s_tready drops; nothing
// is lost or repeated.
module conv3x3_border_modes #(
    parameter int MAX_DIM    = c3bm_pkg::MAX_DIM_DEF,
    parameter int PIXEL_BITS = c3bm_pkg::PIXEL_BITS_DEF,
    parameter int COEF_BITS  = c3bm_pkg::COEF_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [c3bm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [3*COEF_BITS-1:0]              cfg_data,
    // pixel input, tdata: pixel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_tdata,
    // result output, tdata: out_row, out_col, value, is_border
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [c3bm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import c3bm_pkg::*;

`include "conv3x3_border_modes_assert.svh"

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int KERN_W = 3 * COEF_BITS;
    localparam int PROD_W = PIXEL_BITS + COEF_BITS + 1;
    localparam int SUM_W  = (PROD_W + 4 > VALUE_W) ? PROD_W + 4 : VALUE_W;

    // configuration registers
    logic [DIM_REG_W-1:0] rows_cfg_reg;
    logic [DIM_REG_W-1:0] cols_cfg_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [KERN_W-1:0]    kern_reg [3];

    // position of the next pixel
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;

    // line store memory and its per-column valid bits
    logic [2*PIXEL_BITS-1:0] line_mem [MAX_DIM];
    logic [2*PIXEL_BITS-1:0] line_rd_reg;
    logic                    vld_new_reg [MAX_DIM];
    logic                    vld_old_reg [MAX_DIM];
    logic                    rd_vnew_reg, rd_vold_reg;

    // stage 1
    logic                  s1_valid_reg, s1_valid_next;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [IDX_W-1:0]      s1_j_reg;
    logic [N_SLOTS-1:0]    s1_mask_reg;
    logic                  s1_a_int_reg;
    logic [COORD_W-1:0]    s1_row_reg [N_SLOTS];
    logic [COORD_W-1:0]    s1_col_reg [N_SLOTS];

    // window
    logic [PIXEL_BITS-1:0] win_reg  [3][3];
    logic [PIXEL_BITS-1:0] win_next [3][3];

    // stage 2
    logic                     s2_valid_reg, s2_valid_next;
    logic signed [PROD_W-1:0] s2_prod_reg  [3][3];
    logic signed [PROD_W-1:0] prod_next    [3][3];
    result_t                  s2_slot_reg  [N_SLOTS];
    result_t                  slot_next    [N_SLOTS];
    logic [N_SLOTS-1:0]       s2_mask_reg;
    logic                     s2_a_int_reg;

    // result burst and output register
    result_t              b_slot_reg [N_SLOTS];
    result_t              b_load     [N_SLOTS];
    logic [N_SLOTS-1:0]   b_mask_reg, b_mask_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    // combinational helpers
    logic [DIM_W-1:0]      dim_r, dim_c;
    logic                  restart, drop, accept, s1_move, s2_load_ok, out_load, burst_ready;
    logic                  last_col, last_row, a_int;
    logic [IDX_W-1:0]      acc_i, acc_j, i_m1, i_m2, j_m1, j_m2;
    logic [N_SLOTS-1:0]    acc_mask, b_pick, b_rest;
    logic [COORD_W-1:0]    acc_row [N_SLOTS];
    logic [COORD_W-1:0]    acc_col [N_SLOTS];
    logic [PIXEL_BITS-1:0] older_rd, newer_rd;
    logic signed [SUM_W-1:0] sum_all;
    result_t               b_sel;

    // effective dimension, clamped to the supported range
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
        int vi;
        vi = int'(v);
        if (vi < MIN_DIM) begin
            vi = MIN_DIM;
        end else if (vi > MAX_DIM) begin
            vi = MAX_DIM;
        end
        return DIM_W'(vi);
    endfunction

    // border value of a ring result
    function automatic logic [VALUE_W-1:0] ring_value(input logic [MODE_W-1:0] mode,
                                                      input logic [PIXEL_BITS-1:0] pix);
        return (mode == MODE_ZERO) ? '0 : VALUE_W'(pix);
    endfunction

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= DIM_REG_W'(16);
            cols_cfg_reg <= DIM_REG_W'(16);
            mode_reg     <= MODE_COPY;
            kern_reg[0]  <= '0;
            kern_reg[1]  <= '0;
            kern_reg[2]  <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_ROWS:    rows_cfg_reg <= cfg_data[DIM_REG_W-1:0];
                REG_IMAGE_COLS:    cols_cfg_reg <= cfg_data[DIM_REG_W-1:0];
                REG_BORDER_MODE:   mode_reg     <= cfg_data[MODE_W-1:0];
                REG_KERNEL_TOP:    kern_reg[0]  <= cfg_data;
                REG_KERNEL_MIDDLE: kern_reg[1]  <= cfg_data;
                REG_KERNEL_BOTTOM: kern_reg[2]  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign dim_r = clamp_dim(rows_cfg_reg);
    assign dim_c = clamp_dim(cols_cfg_reg);
    assign drop  = (mode_reg >= MODE_NONE);

    // handshake chain
    assign out_load    = !m_tvalid_reg || m_tready;
    assign b_pick      = b_mask_reg & (~b_mask_reg + N_SLOTS'(1));
    assign b_rest      = b_mask_reg & ~b_pick;
    assign burst_ready = (b_mask_reg == '0) || (out_load && (b_rest == '0));
    assign s2_load_ok  = !s2_valid_reg || burst_ready;
    assign s1_move     = s1_valid_reg && s2_load_ok;
    assign s_tready    = !s1_valid_reg || s2_load_ok;
    assign accept      = s_tvalid && s_tready;

    // position of the accepted pixel and the results it causes
    always_comb begin
        restart  = (DIM_W'(row_reg) >= dim_r) || (DIM_W'(col_reg) >= dim_c);
        acc_i    = restart ? '0 : row_reg;
        acc_j    = restart ? '0 : col_reg;
        last_col = (DIM_W'(acc_j) == dim_c - DIM_W'(1));
        last_row = (DIM_W'(acc_i) == dim_r - DIM_W'(1));
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : acc_i + IDX_W'(1);
        end else begin
            col_next = acc_j + IDX_W'(1);
            row_next = acc_i;
        end
        i_m1  = acc_i - IDX_W'(1);
        i_m2  = acc_i - IDX_W'(2);
        j_m1  = acc_j - IDX_W'(1);
        j_m2  = acc_j - IDX_W'(2);
        a_int = (acc_i >= IDX_W'(2)) && (acc_j >= IDX_W'(2));
        // ordered by row, then column: (i-1,j-1) (i-1,j) (i,j-1) (i,j)
        acc_mask[0] = (acc_i != '0) && (acc_j != '0) && (a_int || !drop);
        acc_mask[1] = (acc_i != '0) && (acc_j != '0) && last_col && !drop;
        acc_mask[2] = last_row && (acc_j != '0) && !drop;
        acc_mask[3] = last_row && (acc_j != '0) && last_col && !drop;
        acc_row[0]  = drop ? COORD_W'(i_m2) : COORD_W'(i_m1);
        acc_col[0]  = drop ? COORD_W'(j_m2) : COORD_W'(j_m1);
        acc_row[1]  = COORD_W'(i_m1);
        acc_col[1]  = COORD_W'(acc_j);
        acc_row[2]  = COORD_W'(acc_i);
        acc_col[2]  = COORD_W'(j_m1);
        acc_row[3]  = COORD_W'(acc_i);
        acc_col[3]  = COORD_W'(acc_j);
    end

    // position counters and stage 1 control
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (accept) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg <= s_tdata[PIXEL_BITS-1:0];
            s1_j_reg     <= acc_j;
            s1_mask_reg  <= acc_mask;
            s1_a_int_reg <= a_int;
            for (int k = 0; k < N_SLOTS; k++) begin
                s1_row_reg[k] <= acc_row[k];
                s1_col_reg[k] <= acc_col[k];
            end
        end
    end

    // line store read on accept, write back when stage 1 moves on
    always_ff @(posedge aclk) begin
        if (accept) begin
            line_rd_reg <= line_mem[acc_j];
        end
        if (s1_move) begin
            line_mem[s1_j_reg] <= {s1_pixel_reg, newer_rd};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_DIM; k++) begin
                vld_new_reg[k] <= 1'b0;
                vld_old_reg[k] <= 1'b0;
            end
            rd_vnew_reg <= 1'b0;
            rd_vold_reg <= 1'b0;
        end else begin
            if (accept) begin
                rd_vnew_reg <= vld_new_reg[acc_j];
                rd_vold_reg <= vld_old_reg[acc_j];
            end
            if (s1_move) begin
                vld_old_reg[s1_j_reg] <= rd_vnew_reg;
                vld_new_reg[s1_j_reg] <= 1'b1;
            end
        end
    end

    assign newer_rd = rd_vnew_reg ? line_rd_reg[2*PIXEL_BITS-1:PIXEL_BITS] : '0;
    assign older_rd = rd_vold_reg ? line_rd_reg[PIXEL_BITS-1:0] : '0;

    // window shift, products and ring values
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            win_next[a][0] = win_reg[a][1];
            win_next[a][1] = win_reg[a][2];
        end
        win_next[0][2] = older_rd;
        win_next[1][2] = newer_rd;
        win_next[2][2] = s1_pixel_reg;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                prod_next[a][b] = $signed({1'b0, win_next[a][b]})
                                * $signed(kern_reg[a][b*COEF_BITS +: COEF_BITS]);
            end
        end
        for (int k = 0; k < N_SLOTS; k++) begin
            slot_next[k].row    = s1_row_reg[k];
            slot_next[k].col    = s1_col_reg[k];
            slot_next[k].border = 1'b1;
        end
        slot_next[0].border = !s1_a_int_reg;
        slot_next[0].value  = ring_value(mode_reg, win_next[1][1]);
        slot_next[1].value  = ring_value(mode_reg, win_next[1][2]);
        slot_next[2].value  = ring_value(mode_reg, win_next[2][1]);
        slot_next[3].value  = ring_value(mode_reg, win_next[2][2]);
    end

    // stage 2 control
    always_comb begin
        s2_valid_next = s2_valid_reg;
        if (s1_move) begin
            s2_valid_next = 1'b1;
        end else if (burst_ready) begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    // window and stage 2 payload
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            win_reg      <= win_next;
            s2_prod_reg  <= prod_next;
            s2_slot_reg  <= slot_next;
            s2_mask_reg  <= s1_mask_reg;
            s2_a_int_reg <= s1_a_int_reg;
        end
    end

    // window sum
    always_comb begin
        sum_all = '0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                sum_all = sum_all + SUM_W'(s2_prod_reg[a][b]);
            end
        end
    end

    // slots entering the burst, window sum in the first one when interior
    always_comb begin
        b_load = s2_slot_reg;
        if (s2_a_int_reg) begin
            b_load[0].value = sum_all[VALUE_W-1:0];
        end
    end

    // burst pick, lowest pending slot first
    always_comb begin
        b_sel = '0;
        for (int k = 0; k < N_SLOTS; k++) begin
            if (b_pick[k]) begin
                b_sel = b_slot_reg[k];
            end
        end
        b_mask_next = b_mask_reg;
        if (out_load && (b_mask_reg != '0)) begin
            b_mask_next = b_rest;
        end
        if (s2_valid_reg && burst_ready) begin
            b_mask_next = s2_mask_reg;
        end
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = (b_mask_reg != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_mask_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            b_mask_reg   <= b_mask_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // burst slots and output word
    always_ff @(posedge aclk) begin
        if (s2_valid_reg && burst_ready) begin
            b_slot_reg <= b_load;
        end
        if (out_load && (b_mask_reg != '0)) begin
            m_tdata_reg <= pack_result(b_sel);
            m_tlast_reg <= (b_rest == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
    `CBM_ASSERT(a_line_rw_apart, aclk, aresetn,
                (accept && s1_move) |-> (acc_j != s1_j_reg))
    `CBM_ASSERT(a_stall_full, aclk, aresetn,
                !s_tready |-> (s1_valid_reg && s2_valid_reg && (b_mask_reg != '0)))
    `CBM_ASSERT(a_line_valid_order, aclk, aresetn, rd_vold_reg |-> rd_vnew_reg)
    `CBM_ASSERT_RST(a_reset_quiet, aclk,
                    !aresetn |=> (!m_tvalid_reg && !s1_valid_reg && !s2_valid_reg))

endmodule

>>> tb/conv3x3_border_modes_tb.sv
`timescale 1ns / 1ps

module conv3x3_border_modes_tb;
    import c3bm_pkg::*;

    localparam int DIM_MAX       = MAX_DIM_DEF;
    localparam int VAL_LSB       = 2 * COORD_W;
    localparam int BORDER_BIT    = VAL_LSB + VALUE_W;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PIXELS = 422;

    // one expected result word
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VALUE_W-1:0] value;
        logic               border;
        logic               last;
    } conv_result_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [3*COEF_BITS_DEF-1:0] cfg_data  = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [7:0]                 s_tdata   = '0;   // pixel
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]       m_tdata;          // out_row, out_col, value, is_border
    logic                       m_tlast;

    // predictor copy of registers and pixel history
    logic [4:0]        rows_reg;
    logic [4:0]        cols_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [23:0]       kernel_rows [3];
    logic [7:0]        older_line [DIM_MAX];
    logic [7:0]        newer_line [DIM_MAX];
    logic [7:0]        win [3][3];
    int unsigned       row_pos;
    int unsigned       col_pos;

    conv_result_t pending_results [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           stall_left     = 0;
    bit           gaps_on        = 1'b1;

    conv3x3_border_modes DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("conv3x3_border_modes_tb: FAIL");
            $finish;
        end
    end

    // result receiver with stall bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge aclk) begin : check_results
        conv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: tdata %h tlast %b", m_tdata, m_tlast);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[COORD_W-1:0] !== want.row
                        || m_tdata[VAL_LSB-1:COORD_W] !== want.col
                        || m_tdata[BORDER_BIT-1:VAL_LSB] !== want.value
                        || m_tdata[BORDER_BIT] !== want.border
                        || m_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("result mismatch: expected row %0d col %0d value %0d",
                               want.row, want.col, $signed(want.value));
                        $write(" border %b last %b, got row %0d col %0d",
                               want.border, want.last, m_tdata[COORD_W-1:0],
                               m_tdata[VAL_LSB-1:COORD_W]);
                        $display(" value %0d border %b last %b",
                                 $signed(m_tdata[BORDER_BIT-1:VAL_LSB]),
                                 m_tdata[BORDER_BIT], m_tlast);
                    end
                end
            end
        end
    end

    function automatic int unsigned clamp_dim(input logic [4:0] v);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > DIM_MAX) return DIM_MAX;
        return 32'(v);
    endfunction

    function automatic int window_sum();
        int acc;
        acc = 0;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                acc += int'(win[a][b]) * int'($signed(kernel_rows[a][8*b +: 8]));
        return acc;
    endfunction

    // one output position; returns 0 when the mode drops it
    function automatic bit make_result(input int unsigned r, input int unsigned c,
                                       input logic [7:0] pix, input int unsigned nrows,
                                       input int unsigned ncols, output conv_result_t res);
        int unsigned orow;
        int unsigned ocol;
        int          acc;
        bit          drop_ring;
        drop_ring = mode_reg >= MODE_NONE;
        orow = r;
        ocol = c;
        res  = '0;
        if (r >= 1 && r <= nrows - 2 && c >= 1 && c <= ncols - 2) begin
            acc = window_sum();
            res.value = acc[VALUE_W-1:0];
            // interior-only image is shifted up and left by one
            if (drop_ring) begin
                orow = r - 1;
                ocol = c - 1;
            end
        end else begin
            if (drop_ring) return 1'b0;
            res.value  = (mode_reg == MODE_COPY) ? {{(VALUE_W-8){1'b0}}, pix} : '0;
            res.border = 1'b1;
        end
        res.row = orow[COORD_W-1:0];
        res.col = ocol[COORD_W-1:0];
        return 1'b1;
    endfunction

    // advance the window by one pixel and queue the results it completes
    task automatic convolve_pixel(input logic [7:0] pix);
        int unsigned  nrows;
        int unsigned  ncols;
        int unsigned  i;
        int unsigned  j;
        int unsigned  cand_r [4];
        int unsigned  cand_c [4];
        logic [7:0]   cand_p [4];
        conv_result_t batch [4];
        conv_result_t res;
        int           k;
        int           n;
        nrows = clamp_dim(rows_reg);
        ncols = clamp_dim(cols_reg);
        k = 0;
        n = 0;
        // position left outside a shrunken image restarts the frame
        if (row_pos >= nrows || col_pos >= ncols) begin
            row_pos = 0;
            col_pos = 0;
        end
        i = row_pos;
        j = col_pos;
        for (int a = 0; a < 3; a++) begin
            win[a][0] = win[a][1];
            win[a][1] = win[a][2];
        end
        win[0][2] = older_line[j];
        win[1][2] = newer_line[j];
        win[2][2] = pix;
        older_line[j] = newer_line[j];
        newer_line[j] = pix;

        // positions completed by this pixel, row then column order
        if (i >= 1 && j >= 1) begin
            cand_r[k] = i - 1; cand_c[k] = j - 1; cand_p[k] = win[1][1]; k++;
            if (j == ncols - 1) begin
                cand_r[k] = i - 1; cand_c[k] = j; cand_p[k] = win[1][2]; k++;
            end
        end
        if (i == nrows - 1 && j >= 1) begin
            cand_r[k] = i; cand_c[k] = j - 1; cand_p[k] = win[2][1]; k++;
            if (j == ncols - 1) begin
                cand_r[k] = i; cand_c[k] = j; cand_p[k] = win[2][2]; k++;
            end
        end
        for (int q = 0; q < k; q++) begin
            if (make_result(cand_r[q], cand_c[q], cand_p[q], nrows, ncols, res)) begin
                batch[n] = res;
                n++;
            end
        end
        for (int q = 0; q < n; q++) begin
            if (q == n - 1) batch[q].last = 1'b1;
            pending_results.push_back(batch[q]);
        end

        col_pos = j + 1;
        if (col_pos >= ncols) begin
            col_pos = 0;
            row_pos = i + 1;
            if (row_pos >= nrows) row_pos = 0;
        end
    endtask

    task automatic reset_model();
        rows_reg = 5'd16;
        cols_reg = 5'd16;
        mode_reg = MODE_COPY;
        for (int a = 0; a < 3; a++) begin
            kernel_rows[a] = '0;
            for (int b = 0; b < 3; b++) win[a][b] = '0;
        end
        for (int c = 0; c < DIM_MAX; c++) begin
            older_line[c] = '0;
            newer_line[c] = '0;
        end
        row_pos = 0;
        col_pos = 0;
    endtask

    function automatic logic [23:0] rand24();
        logic [31:0] w;
        w = $urandom;
        return w[23:0];
    endfunction

    // mostly small images, sometimes full size or any register value
    function automatic logic [4:0] pick_dim();
        int v;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 31);
            1:       v = DIM_MAX;
            default: v = $urandom_range(3, 6);
        endcase
        return v[4:0];
    endfunction

    // register write; called at a falling edge, leaves cfg_valid high
    task automatic write_reg(input cfg_reg_t idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_IMAGE_ROWS:    rows_reg = data[4:0];
            REG_IMAGE_COLS:    cols_reg = data[4:0];
            REG_BORDER_MODE:   mode_reg = data[MODE_W-1:0];
            REG_KERNEL_TOP:    kernel_rows[0] = data;
            REG_KERNEL_MIDDLE: kernel_rows[1] = data;
            REG_KERNEL_BOTTOM: kernel_rows[2] = data;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // all six registers, unused upper data bits random
    task automatic configure(input logic [4:0] nrows, input logic [4:0] ncols,
                             input logic [MODE_W-1:0] mode, input logic [23:0] ktop,
                             input logic [23:0] kmid, input logic [23:0] kbot);
        logic [23:0] junk;
        junk = rand24();
        write_reg(REG_IMAGE_ROWS, {junk[23:5], nrows});
        write_reg(REG_IMAGE_COLS, {junk[23:5], ncols});
        write_reg(REG_BORDER_MODE, {junk[23:MODE_W], mode});
        write_reg(REG_KERNEL_TOP, ktop);
        write_reg(REG_KERNEL_MIDDLE, kmid);
        write_reg(REG_KERNEL_BOTTOM, kbot);
        cfg_valid <= 1'b0;
    endtask

    // one pixel word, optional idle burst first; called at a falling edge
    task automatic send_pixel(input logic [7:0] pix);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        convolve_pixel(pix);
        @(negedge aclk);
    endtask

    // wait until every expected word is out and the pipeline is empty
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // reset register values: 16x16, copy ring, zero kernel
    task automatic test_reset_state();
        for (int k = 0; k < 20; k++) begin
            if (k < 8) send_pixel(k[0] ? 8'hFF : 8'h00);
            else send_pixel(8'($urandom_range(0, 255)));
        end
        wait_drain();
    endtask

    // most negative sum; shrinking to 3x3 mid-row restarts the frame
    task automatic test_kernel_extremes();
        configure(5'd3, 5'd3, MODE_COPY, 24'h808080, 24'h808080, 24'h808080);
        repeat (9) send_pixel(8'hFF);
        wait_drain();
    endtask

    // unused mode code drops the ring; clamped dims; most positive sum
    task automatic test_drop_ring();
        configure(5'd0, 5'd2, 2'd3, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
        repeat (9) send_pixel(8'hFF);
        wait_drain();
    endtask

    // random settings, whole frames mostly, partial frames now and then
    task automatic test_random_frames();
        int          sent;
        int          count;
        int          big_frames;
        int          mode_sel;
        int unsigned nrows;
        int unsigned ncols;
        logic [4:0]  rsel;
        logic [4:0]  csel;
        logic [7:0]  pix;
        sent = 0;
        big_frames = 0;
        while (sent < RANDOM_PIXELS) begin
            if (sent > RANDOM_PIXELS * 4 / 5) gaps_on = 1'b0;
            rsel = pick_dim();
            csel = pick_dim();
            mode_sel = $urandom_range(0, 3);
            configure(rsel, csel, mode_sel[MODE_W-1:0], rand24(), rand24(), rand24());
            nrows = clamp_dim(rsel);
            ncols = clamp_dim(csel);
            count = nrows * ncols;
            if (count > 80) begin
                if (big_frames > 0) count = $urandom_range(10, 60);
                big_frames++;
            end else if ($urandom_range(0, 4) == 0) begin
                count = $urandom_range(1, count);
            end else begin
                count = count * $urandom_range(1, 2);
            end
            if (count > RANDOM_PIXELS - sent) count = RANDOM_PIXELS - sent;
            for (int k = 0; k < count; k++) begin
                if ($urandom_range(0, 7) == 0) pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else pix = 8'($urandom_range(0, 255));
                send_pixel(pix);
            end
            sent += count;
            wait_drain();
        end
    endtask

    initial begin
        reset_model();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_state();
        test_kernel_extremes();
        test_drop_ring();
        test_random_frames();
        wait_drain();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("conv3x3_border_modes_tb: PASS");
        end else begin
            $display("conv3x3_border_modes_tb: FAIL");
        end
        $finish;
    end

endmodule
